// ===== hw/rtl/pf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pf_pkg;

    // Key square geometry and letter codes (letter index a=0 .. z=25).
    localparam int unsigned SIDE     = 5;
    localparam int unsigned CELL_W   = 5;
    localparam int unsigned CASE_GAP = 32;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned LOW_W    = 50;
    localparam int unsigned MID_W    = 50;
    localparam int unsigned HIGH_W   = 25;

    typedef logic [CELL_W-1:0] t_letter;
    typedef logic [2:0]        t_coord;

    localparam t_letter LETTER_I = t_letter'(8);
    localparam t_letter LETTER_J = t_letter'(9);
    localparam t_letter LETTER_Z = t_letter'(25);

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;

    // Register indexes, taken from paddr[4:3].
    typedef enum logic [1:0] {
        REG_LOW   = 2'd0,
        REG_MID   = 2'd1,
        REG_HIGH  = 2'd2,
        REG_SPARE = 2'd3
    } t_reg_idx;

    typedef struct packed {
        t_coord row;
        t_coord col;
    } t_pos;

    typedef t_letter [SIDE-1:0] t_row;
    typedef t_row    [SIDE-1:0] t_square;

    // Unpack the three configuration words into a row-major square.
    function automatic t_square build_square(
        input logic [LOW_W-1:0]  low,
        input logic [MID_W-1:0]  mid,
        input logic [HIGH_W-1:0] high
    );
        t_square sq;
        int      k;
        for (int r = 0; r < SIDE; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                k = r * SIDE + c;
                if (k < 10) begin
                    sq[r][c] = low[CELL_W*k +: CELL_W];
                end else if (k < 20) begin
                    sq[r][c] = mid[CELL_W*(k-10) +: CELL_W];
                end else begin
                    sq[r][c] = high[CELL_W*(k-20) +: CELL_W];
                end
            end
        end
        return sq;
    endfunction

    // Lowest-numbered cell holding the letter; cell 0 when it is absent.
    function automatic t_pos find_pos(input t_square sq, input t_letter letter);
        t_pos pos;
        pos.row = '0;
        pos.col = '0;
        for (int r = SIDE - 1; r >= 0; r--) begin
            for (int c = SIDE - 1; c >= 0; c--) begin
                if (sq[r][c] == letter) begin
                    pos.row = t_coord'(r);
                    pos.col = t_coord'(c);
                end
            end
        end
        return pos;
    endfunction

    // Step one place along a row or column, wrapping at the edge.
    function automatic t_coord wrap_inc(input t_coord v);
        return (v == t_coord'(SIDE - 1)) ? t_coord'(0) : t_coord'(v + t_coord'(1));
    endfunction

    // Cell value to lowercase ASCII; values past z print as z.
    function automatic logic [6:0] to_ascii(input t_letter v);
        t_letter lim;
        lim = (v > LETTER_Z) ? LETTER_Z : v;
        return 7'(ASCII_LOWER_A) + {2'b00, lim};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/playfair_digraph_encrypt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                 Payload
// s_axis    in         tvalid / tready           tdata[7:0] char_byte, tlast end_of_text
// m_axis    out        tvalid / tready           tdata[6:0] cipher_char, tlast last_of_text
// apb       in         psel, penable, pwrite     paddr[4:3] register, pwdata key square cells
//
// One input item is taken every cycle while the pair register can move. A byte that
// completes a pair reaches the pair register at the next edge; the parallel 25-cell match
// then fills the result register, which hands out the two ciphertext letters one after
// the other, first letter first. A stalled output holds the result and
// pair registers, and input is held off only when the pair register cannot move.
// Reset (synchronous, active low) clears the key square, the pending letter and both stages.
module playfair_digraph_encrypt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] char_byte
    input  logic                       s_axis_tlast,   // end_of_text
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [7:0]                 m_axis_tdata,   // [6:0] cipher_char, [7] zero
    output logic                       m_axis_tlast,   // last_of_text
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pf_pkg::ADDR_W-1:0]  paddr,
    input  logic [pf_pkg::DATA_W-1:0]  pwdata,
    output logic [pf_pkg::DATA_W-1:0]  prdata,
    output logic                       pready
);
    import pf_pkg::*;

    logic [LOW_W-1:0]  r_sq_low;
    logic [MID_W-1:0]  r_sq_mid;
    logic [HIGH_W-1:0] r_sq_high;

    t_letter r_held;
    logic    r_holding;
    t_letter n_held;
    logic    n_holding;

    logic    r_pv;
    t_letter r_pa;
    t_letter r_pb;
    logic    r_plast;

    logic       r_rv;
    logic       r_rsel;
    logic [6:0] r_ra;
    logic [6:0] r_rb;
    logic       r_rlast;

    logic       cfg_wr;
    t_reg_idx   cfg_idx;
    logic       in_accept;
    logic       out_accept;
    logic       res_load;
    logic       pair_ready;

    logic [7:0] folded;
    logic       is_letter;
    t_letter    letter;
    logic       pair_fire;
    t_letter    pair_a;
    t_letter    pair_b;
    logic       pair_last;

    t_square    square;
    t_pos       pos_a;
    t_pos       pos_b;
    t_pos       out_a;
    t_pos       out_b;

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_idx = t_reg_idx'(paddr[4:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_low  <= '0;
            r_sq_mid  <= '0;
            r_sq_high <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_LOW:   r_sq_low  <= pwdata[LOW_W-1:0];
                REG_MID:   r_sq_mid  <= pwdata[MID_W-1:0];
                REG_HIGH:  r_sq_high <= pwdata[HIGH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_LOW:  prdata = DATA_W'(r_sq_low);
            REG_MID:  prdata = DATA_W'(r_sq_mid);
            REG_HIGH: prdata = DATA_W'(r_sq_high);
            default:  prdata = '0;
        endcase
    end

    // Handshakes and stage movement.
    assign out_accept    = m_axis_tvalid && m_axis_tready;
    assign res_load      = r_pv && (!r_rv || (out_accept && r_rsel));
    assign pair_ready    = !r_pv || res_load;
    assign s_axis_tready = pair_ready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Byte decode: fold case, keep letters, map j to i.
    always_comb begin
        if (s_axis_tdata >= ASCII_UPPER_A && s_axis_tdata <= ASCII_UPPER_Z) begin
            folded = s_axis_tdata + 8'(CASE_GAP);
        end else begin
            folded = s_axis_tdata;
        end
        is_letter = (folded >= ASCII_LOWER_A) && (folded <= ASCII_LOWER_Z);
        letter    = t_letter'(folded - ASCII_LOWER_A);
        if (letter == LETTER_J) begin
            letter = LETTER_I;
        end
    end

    // Pairing: decide whether this byte completes a pair and what stays pending.
    always_comb begin
        pair_fire = 1'b0;
        pair_a    = r_held;
        pair_b    = LETTER_Z;
        pair_last = 1'b1;
        n_held    = r_held;
        n_holding = r_holding;
        if (is_letter) begin
            if (r_holding) begin
                pair_fire = 1'b1;
                pair_b    = letter;
                pair_last = s_axis_tlast;
                n_holding = 1'b0;
            end else if (s_axis_tlast) begin
                pair_fire = 1'b1;
                pair_a    = letter;
            end else begin
                n_held    = letter;
                n_holding = 1'b1;
            end
        end else if (s_axis_tlast) begin
            pair_fire = r_holding;
            n_holding = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= '0;
            r_holding <= 1'b0;
        end else if (in_accept) begin
            r_held    <= n_held;
            r_holding <= n_holding;
        end
    end

    // Pair register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (pair_ready) begin
            r_pv <= in_accept && pair_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && pair_fire) begin
            r_pa    <= pair_a;
            r_pb    <= pair_b;
            r_plast <= pair_last;
        end
    end

    // Square lookup and Playfair rules for the registered pair.
    always_comb begin
        square = build_square(r_sq_low, r_sq_mid, r_sq_high);
        pos_a  = find_pos(square, r_pa);
        pos_b  = find_pos(square, r_pb);
        out_a  = pos_a;
        out_b  = pos_b;
        priority if (pos_a.row == pos_b.row) begin
            out_a.col = wrap_inc(pos_a.col);
            out_b.col = wrap_inc(pos_b.col);
        end else if (pos_a.col == pos_b.col) begin
            out_a.row = wrap_inc(pos_a.row);
            out_b.row = wrap_inc(pos_b.row);
        end else begin
            out_a.col = pos_b.col;
            out_b.col = pos_a.col;
        end
    end

    // Result register: two letters sent one after the other.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv   <= 1'b0;
            r_rsel <= 1'b0;
        end else if (res_load) begin
            r_rv   <= 1'b1;
            r_rsel <= 1'b0;
        end else if (out_accept) begin
            r_rv   <= !r_rsel;
            r_rsel <= !r_rsel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_load) begin
            r_ra    <= to_ascii(square[out_a.row][out_a.col]);
            r_rb    <= to_ascii(square[out_b.row][out_b.col]);
            r_rlast <= r_plast;
        end
    end

    assign m_axis_tvalid = r_rv;
    assign m_axis_tdata  = {1'b0, (r_rsel ? r_rb : r_ra)};
    assign m_axis_tlast  = r_rsel && r_rlast;

endmodule

`default_nettype wire

// ===== tb/tb_playfair_digraph_encrypt.sv =====
`timescale 1ns / 1ps

module tb_playfair_digraph_encrypt;

    import pf_pkg::*;

    // One expected ciphertext letter as it should leave the output stream.
    typedef struct packed {
        logic [6:0] letter;
        logic       last;
    } t_cipher_letter;

    // Keeps its own copy of the key square and the pending letter, works out the
    // ciphertext letters that each accepted plaintext byte causes, and compares
    // every output item against the oldest letter still due.
    class t_cipher_checker;
        logic [LOW_W-1:0]  low_cells  = '0;
        logic [MID_W-1:0]  mid_cells  = '0;
        logic [HIGH_W-1:0] high_cells = '0;
        t_letter           held       = '0;
        bit                holding    = 1'b0;
        t_cipher_letter    due_letters[$];
        int                failures   = 0;

        function void note_failure(string msg);
            failures++;
            if (failures <= 10) begin
                $display("[%0t] mismatch: %s", $realtime, msg);
            end
        endfunction

        function void set_reg(t_reg_idx idx, logic [63:0] value);
            case (idx)
                REG_LOW:  low_cells  = value[LOW_W-1:0];
                REG_MID:  mid_cells  = value[MID_W-1:0];
                REG_HIGH: high_cells = value[HIGH_W-1:0];
                default: ;
            endcase
        endfunction

        function t_letter cell_value(int k);
            if (k < 10) begin
                return low_cells[CELL_W*k +: CELL_W];
            end else if (k < 20) begin
                return mid_cells[CELL_W*(k-10) +: CELL_W];
            end
            return high_cells[CELL_W*(k-20) +: CELL_W];
        endfunction

        // First cell that holds the letter; a missing letter sits in the corner cell.
        function int locate(t_letter l);
            for (int k = 0; k < SIDE * SIDE; k++) begin
                if (cell_value(k) == l) begin
                    return k;
                end
            end
            return 0;
        endfunction

        function logic [6:0] letter_ascii(t_letter v);
            if (v > LETTER_Z) begin
                v = LETTER_Z;
            end
            return 7'(ASCII_LOWER_A + v);
        endfunction

        // Append one expected letter at the back of the queue.
        function void queue_letter(logic [6:0] letter, bit last);
            t_cipher_letter entry;
            entry.letter = letter;
            entry.last   = last;
            due_letters.insert(due_letters.size(), entry);
        endfunction

        // Apply the row, column and rectangle rules to one pair of letters.
        function void encipher_pair(t_letter a, t_letter b, bit last);
            int pa, pb, ra, ca, rb, cb, oa, ob;
            pa = locate(a);
            pb = locate(b);
            ra = pa / SIDE;
            ca = pa % SIDE;
            rb = pb / SIDE;
            cb = pb % SIDE;
            if (ra == rb) begin
                oa = ra * SIDE + (ca + 1) % SIDE;
                ob = rb * SIDE + (cb + 1) % SIDE;
            end else if (ca == cb) begin
                oa = ((ra + 1) % SIDE) * SIDE + ca;
                ob = ((rb + 1) % SIDE) * SIDE + cb;
            end else begin
                oa = ra * SIDE + cb;
                ob = rb * SIDE + ca;
            end
            queue_letter(letter_ascii(cell_value(oa)), 1'b0);
            queue_letter(letter_ascii(cell_value(ob)), last);
        endfunction

        // Called for every plaintext item the block accepts.
        function void take_byte(logic [7:0] raw, logic eot);
            logic [7:0] c;
            t_letter    l;
            bit         is_letter;
            c = raw;
            if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
                c = c + 8'(CASE_GAP);
            end
            is_letter = (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z);
            l = t_letter'(c - ASCII_LOWER_A);
            if (l == LETTER_J) begin
                l = LETTER_I;
            end
            if (is_letter) begin
                if (holding) begin
                    holding = 1'b0;
                    encipher_pair(held, l, eot);
                end else if (eot) begin
                    encipher_pair(l, LETTER_Z, 1'b1);
                end else begin
                    held    = l;
                    holding = 1'b1;
                end
            end else if (eot) begin
                if (holding) begin
                    encipher_pair(held, LETTER_Z, 1'b1);
                end
                holding = 1'b0;
            end
        endfunction

        // Called for every ciphertext item the block hands out.
        function void match_letter(logic [6:0] letter, logic last);
            t_cipher_letter want;
            if (due_letters.size() == 0) begin
                note_failure($sformatf("unexpected letter %c last %0b", letter, last));
                return;
            end
            want = due_letters.pop_front();
            if (want.letter !== letter || want.last !== last) begin
                note_failure($sformatf("expected %c last %0b, got %c last %0b",
                                       want.letter, want.last, letter, last));
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;   // [7:0] char_byte
    logic              s_axis_tlast;   // end_of_text
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [7:0]        m_axis_tdata;   // [6:0] cipher_char, [7] zero
    logic              m_axis_tlast;   // last_of_text
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    t_cipher_checker board = new();

    // Idling is allowed while this is set; it is re-rolled in stretches.
    bit      gappy = 1'b1;
    int      hold_off = 0;
    t_letter grid[SIDE*SIDE];

    // Directed plaintext, {end_of_text, char_byte}, on the alphabetical square.
    logic [8:0] opening[$] = '{
        {1'b0, "A"}, {1'b0, "b"}, {1'b0, "a"}, {1'b0, "F"}, {1'b0, 8'h00},
        {1'b0, "a"}, {1'b0, "z"}, {1'b0, 8'hFF}, {1'b0, "Z"}, {1'b0, "j"},
        {1'b0, "J"}, {1'b0, "J"}, {1'b0, 8'h40}, {1'b0, "e"}, {1'b0, 8'h5B},
        {1'b0, "e"}, {1'b0, 8'h60}, {1'b0, 8'h7B}, {1'b0, 8'h20}, {1'b0, "q"},
        {1'b1, 8'h2E}, {1'b1, 8'h80}, {1'b1, "m"}, {1'b0, "x"}, {1'b1, "Y"}
    };

    // Directed plaintext for a square with a missing letter, a repeated letter
    // and a cell value past z.
    logic [8:0] oddities[$] = '{
        {1'b0, "h"}, {1'b0, "a"}, {1'b0, "z"}, {1'b0, "Z"},
        {1'b0, "e"}, {1'b0, "y"}, {1'b0, "y"}, {1'b1, "d"}
    };

    playfair_digraph_encrypt dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Output side: check each accepted item, then decide on the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            board.match_letter(m_axis_tdata[6:0], m_axis_tlast);
        end
        if (hold_off > 0) begin
            hold_off--;
            m_axis_tready <= 1'b0;
        end else if (gappy && $urandom_range(0, 4) == 0) begin
            hold_off = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // One register write: a setup phase, then the access phase.
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_reg(idx, value);
    endtask

    task automatic load_words(input logic [63:0] lo, input logic [63:0] mi,
                              input logic [63:0] hi, input bit poke_spare);
        write_reg(REG_LOW, lo);
        write_reg(REG_MID, mi);
        write_reg(REG_HIGH, hi);
        if (poke_spare) begin
            write_reg(REG_SPARE, {$urandom, $urandom});
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_grid();
        logic [63:0] lo, mi, hi;
        lo = '0;
        mi = '0;
        hi = '0;
        for (int k = 0; k < 10; k++) begin
            lo[CELL_W*k +: CELL_W] = grid[k];
            mi[CELL_W*k +: CELL_W] = grid[k+10];
        end
        for (int k = 0; k < 5; k++) begin
            hi[CELL_W*k +: CELL_W] = grid[k+20];
        end
        load_words(lo, mi, hi, 1'b0);
    endtask

    // Alphabetical square with j left out.
    function automatic void fill_ordered();
        for (int k = 0; k < SIDE * SIDE; k++) begin
            grid[k] = t_letter'((k < LETTER_J) ? k : k + 1);
        end
    endfunction

    function automatic void shuffle_grid();
        int      m;
        t_letter tmp;
        fill_ordered();
        for (int k = SIDE * SIDE - 1; k > 0; k--) begin
            m       = $urandom_range(0, k);
            tmp     = grid[k];
            grid[k] = grid[m];
            grid[m] = tmp;
        end
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic eot);
        if (gappy && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= eot;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.take_byte(ch, eot);
    endtask

    // Drop valid and wait until every due letter is out and the pipe is empty.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (board.due_letters.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Mostly letters in either case with some doubles, some raw bytes as noise.
    task automatic run_phase(input int count, input bit lively);
        logic [7:0] ch;
        int         r;
        ch = "a";
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                gappy = lively && ($urandom_range(0, 2) != 0);
            end
            r = $urandom_range(0, 99);
            if (r >= 12 && r < 85) begin
                ch = 8'(($urandom_range(0, 1) ? ASCII_UPPER_A : ASCII_LOWER_A)
                        + $urandom_range(0, 25));
            end else if (r >= 85) begin
                ch = 8'($urandom_range(0, 255));
            end
            send_char(ch, $urandom_range(0, 24) == 0);
        end
        settle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every rule, case folding, j, non-letters, end of text.
        fill_ordered();
        load_grid();
        foreach (opening[k]) begin
            send_char(opening[k][7:0], opening[k][8]);
        end
        settle();

        fill_ordered();
        grid[7]  = t_letter'(0);
        grid[24] = t_letter'(31);
        load_grid();
        foreach (oddities[k]) begin
            send_char(oddities[k][7:0], oddities[k][8]);
        end
        settle();

        // Random part over several key squares, extremes among them.
        shuffle_grid();
        load_grid();
        run_phase(220, 1'b1);

        load_words('0, '0, '0, 1'b0);
        run_phase(220, 1'b1);

        load_words('1, '1, '1, 1'b1);
        run_phase(220, 1'b1);

        load_words({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        run_phase(220, 1'b1);

        // Last stretch runs without idling on either side.
        shuffle_grid();
        load_grid();
        run_phase(220, 1'b0);

        repeat (8) @(posedge i_clk);
        if (board.due_letters.size() != 0) begin
            board.note_failure($sformatf("%0d letters never arrived",
                                         board.due_letters.size()));
        end
        if (board.failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== playfair_digraph_encrypt.f =====
hw/rtl/pf_pkg.sv
hw/rtl/playfair_digraph_encrypt.sv
tb/tb_playfair_digraph_encrypt.sv
